// ===== sv/lruce_pkg.sv =====
package lruce_pkg;

  // Width of the key field on the stream ports
  localparam int KEY_W = 16;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_CAPACITY = '0;
  localparam int CAP_W = 5;

  // Operation codes carried in the input transfer
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Release reasons carried in tuser of the result transfer
  localparam logic [1:0] RSN_NONE   = 2'd0;
  localparam logic [1:0] RSN_STALE  = 2'd1;
  localparam logic [1:0] RSN_REMOVE = 2'd2;
  localparam logic [1:0] RSN_EVICT  = 2'd3;

  // What a cell loads at the next edge
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PREV,
    OP_NEXT,
    OP_LOAD,
    OP_DROP
  } cell_op_t;

endpackage

// ===== sv/lruce_cell.sv =====
module lruce_cell #(
  parameter int KW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lruce_pkg::cell_op_t op,
  input  logic [KW-1:0]      cmp_key,
  input  logic [KW-1:0]      prev_key,
  input  logic               prev_valid,
  input  logic [KW-1:0]      next_key,
  input  logic               next_valid,
  output logic [KW-1:0]      key,
  output logic               valid,
  output logic               hit
);
  import lruce_pkg::*;

  logic [KW-1:0] key_r;
  logic          valid_r;

  always_ff @(posedge clk) begin
    case (op)
      OP_PREV: key_r <= prev_key;
      OP_NEXT: key_r <= next_key;
      OP_LOAD: key_r <= cmp_key;
      default: key_r <= key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (op)
        OP_PREV: valid_r <= prev_valid;
        OP_NEXT: valid_r <= next_valid;
        OP_LOAD: valid_r <= 1'b1;
        OP_DROP: valid_r <= 1'b0;
        default: valid_r <= valid_r;
      endcase
    end
  end

  assign key   = key_r;
  assign valid = valid_r;
  assign hit   = valid_r && (key_r == cmp_key);

endmodule

// ===== sv/lru_capacity_eviction_table.sv =====
// An item is accepted in S_IDLE and looked up and applied in S_LOOK; each capacity
// eviction then takes a pass through S_EVICT, as the chain drops one least-recent entry
// per cycle while the result register is free. Only one item is in the table at a time,
// and the table holds while the result register is stalled.
// Reset: synchronous rst_n clears the valid bits, entry count, capacity and control state;
// keys need no reset and there is no clearing pass.
module lru_capacity_eviction_table #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // [0] mode, [16:1] key, [23:17] zero
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [15:0] released_key
  output logic [1:0]                    out_tuser,  // [1:0] reason
  output logic                          out_tlast,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lruce_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import lruce_pkg::*;

  localparam int SLOTS = ENTRIES + 1;
  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int IW    = $clog2(SLOTS);
  localparam int LW    = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EVICT} state_t;

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic [KW-1:0]     item_key_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CAP_W-1:0]  capacity_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [15:0]       out_tdata_r, out_tdata_nxt;
  logic [1:0]        out_tuser_r, out_tuser_nxt;
  logic              out_tlast_r, out_tlast_nxt;

  logic [KW-1:0]     cell_key [SLOTS];
  logic [SLOTS-1:0]  cell_valid;
  logic [SLOTS-1:0]  hit_vec;
  logic [SLOTS-1:0]  hit_upto;
  cell_op_t          cell_op [SLOTS];

  logic              out_free;
  logic              any_hit;
  logic [LW-1:0]     limit_w;
  logic [CW-1:0]     count_after;
  logic              over;
  logic              evict_last;
  logic [IW-1:0]     top_idx;
  logic              cfg_wr;

  // chain of cells, rank 0 (most recent) at index 0
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic [KW-1:0] prev_key, next_key;
    logic          prev_valid, next_valid;
    if (g == 0) begin : g_first
      assign prev_key   = '0;
      assign prev_valid = 1'b0;
    end else begin : g_mid
      assign prev_key   = cell_key[g-1];
      assign prev_valid = cell_valid[g-1];
    end
    if (g == SLOTS - 1) begin : g_last
      assign next_key   = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_key   = cell_key[g+1];
      assign next_valid = cell_valid[g+1];
    end
    lruce_cell #(.KW(KW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (cell_op[g]),
      .cmp_key    (item_key_r),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .next_key   (next_key),
      .next_valid (next_valid),
      .key        (cell_key[g]),
      .valid      (cell_valid[g]),
      .hit        (hit_vec[g])
    );
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_AW-1:2] == REG_CAPACITY);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_CAPACITY) ? 32'(capacity_r) : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign out_free = !out_tvalid_r || out_tready;
  assign any_hit  = |hit_vec;
  assign limit_w  = (LW'(capacity_r) > LW'(ENTRIES)) ? LW'(ENTRIES) : LW'(capacity_r);
  assign top_idx  = IW'(count_r - CW'(1));

  // hit_upto[i]: the matching entry sits at rank i or below
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_upto[i] = |(hit_vec << (SLOTS - 1 - i));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    count_after    = any_hit ? count_r : count_r + CW'(1);
    over           = LW'(count_after) > limit_w;
    evict_last     = !(LW'(count_r - CW'(1)) > limit_w);
    for (int i = 0; i < SLOTS; i++) begin
      cell_op[i] = OP_HOLD;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          if (mode_r == MODE_REMOVE) begin
            // entries above the match close the gap
            for (int i = 0; i < SLOTS; i++) begin
              if (hit_upto[i]) cell_op[i] = OP_NEXT;
            end
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = any_hit ? 16'(item_key_r) : '0;
            out_tuser_nxt  = any_hit ? RSN_REMOVE : RSN_NONE;
            out_tlast_nxt  = 1'b1;
            if (any_hit) count_nxt = count_r - CW'(1);
            state_nxt = S_IDLE;
          end else begin
            // new key enters at rank 0; entries up to the stale one move up
            cell_op[0] = OP_LOAD;
            for (int i = 1; i < SLOTS; i++) begin
              if (!hit_upto[i-1]) cell_op[i] = OP_PREV;
            end
            count_nxt = count_after;
            if (any_hit) begin
              out_tvalid_nxt = 1'b1;
              out_tdata_nxt  = 16'(item_key_r);
              out_tuser_nxt  = RSN_STALE;
              out_tlast_nxt  = !over;
            end else if (!over) begin
              out_tvalid_nxt = 1'b1;
              out_tdata_nxt  = '0;
              out_tuser_nxt  = RSN_NONE;
              out_tlast_nxt  = 1'b1;
            end
            state_nxt = over ? S_EVICT : S_IDLE;
          end
        end
      end
      S_EVICT: begin
        if (out_free) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (CW'(i + 1) == count_r) cell_op[i] = OP_DROP;
          end
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = 16'(cell_key[top_idx]);
          out_tuser_nxt  = RSN_EVICT;
          out_tlast_nxt  = evict_last;
          count_nxt      = count_r - CW'(1);
          if (evict_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      capacity_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr) capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
    if (in_tvalid && in_tready) begin
      mode_r     <= in_tdata[0];
      item_key_r <= in_tdata[KW:1];
    end
  end

  // valid cells form a run from rank 0; the check is that their number equals the count
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("entry count disagrees with valid cells");

  // between items the table is within its size
  a_idle_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (int'(count_r) <= ENTRIES))
    else $error("table over size while idle");

  // a key is never held twice
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> $onehot0(hit_vec))
    else $error("duplicate key in table");

  // eviction only starts once the count exceeds the limit
  a_evict_needed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |-> (LW'(count_r) > limit_w))
    else $error("eviction with table within capacity");

endmodule

// ===== verif/tb_lru_capacity_eviction_table.sv =====
`timescale 1ns / 1ps

module tb_lru_capacity_eviction_table;
  import lruce_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 26;

  typedef struct packed {
    logic        mode;
    logic [15:0] key;
  } cache_op_t;

  typedef struct packed {
    logic [15:0] key;
    logic [1:0]  reason;
    logic        last;
  } release_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata    = '0;   // [0] mode, [16:1] key, [23:17] zero
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [15:0]         out_tdata;          // [15:0] released_key
  logic [1:0]          out_tuser;          // [1:0] reason
  logic                out_tlast;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  lru_capacity_eviction_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow of the block: keys in recency order, index 0 most recent
  logic [15:0] lru_keys[$];
  logic [4:0]  capacity_shadow = '0;
  release_t    release_q[$];
  cache_op_t   pending_ops[$];

  bit          no_idle = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          ops_accepted = 0;
  int          results_seen = 0;
  int          run_len = 0;
  int          longest_run = 0;
  int          reason_seen[4] = '{0, 0, 0, 0};

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void apply_cache_op(input logic mode, input logic [15:0] key);
    release_t    batch[$];
    release_t    rel;
    int          hit;
    int unsigned limit;
    hit = -1;
    foreach (lru_keys[i])
      if (lru_keys[i] == key) hit = i;
    limit = (capacity_shadow > ENTRIES) ? ENTRIES : capacity_shadow;
    if (hit >= 0) begin
      lru_keys.delete(hit);
      rel = '{key: key, reason: (mode == MODE_REMOVE) ? RSN_REMOVE : RSN_STALE, last: 1'b0};
      batch.push_back(rel);
    end
    if (mode == MODE_ADD) begin
      lru_keys.push_front(key);
      // capacity is applied only here, so a lowered limit can evict several at once
      while (lru_keys.size() > limit) begin
        rel = '{key: lru_keys[$], reason: RSN_EVICT, last: 1'b0};
        batch.push_back(rel);
        lru_keys.pop_back();
      end
    end
    if (batch.size() == 0) begin
      rel = '{key: 16'h0000, reason: RSN_NONE, last: 1'b0};
      batch.push_back(rel);
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) release_q.push_back(batch[i]);
  endfunction

  // input side
  int unsigned op_gap = 0;
  cache_op_t   next_op;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      op_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_cache_op(in_tdata[0], in_tdata[16:1]);
        ops_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (op_gap > 0) begin
          op_gap    <= op_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op   = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'b0, next_op.key, next_op.mode};
          op_gap    <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  int unsigned stall_left = 0;
  release_t    want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (release_q.size() == 0) begin
          $error("unexpected result transfer: key %h reason %0d last %0b",
                 out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = release_q.pop_front();
          if (out_tdata !== want.key) begin
            $error("released_key: expected %h, got %h", want.key, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.reason) begin
            $error("reason: expected %0d, got %0d", want.reason, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            fail_count++;
          end
          reason_seen[want.reason]++;
        end
        run_len++;
        if (out_tlast) begin
          if (run_len > longest_run) longest_run = run_len;
          run_len = 0;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  task automatic queue_op(input logic mode, input logic [15:0] key);
    cache_op_t op;
    op.mode = mode;
    op.key  = key;
    pending_ops.push_back(op);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_tvalid || release_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_CAPACITY, 2'b00};
    cfg_pwdata  <= {27'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    capacity_shadow = value;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {27'b0, value}) begin
      $error("capacity readback: expected %h, got %h", {27'b0, value}, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lru_capacity_eviction_table regression: fail");
    $finish;
  end

  logic [4:0]  phase_caps[RAND_PHASES];
  logic [15:0] pool_base;
  int unsigned pool_size;
  int          ph;
  int          n;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity still zero from reset: the new key goes straight back out
    queue_op(MODE_ADD, 16'h0000);
    queue_op(MODE_REMOVE, 16'hFFFF);
    wait_idle();

    write_capacity(5'd3);
    queue_op(MODE_ADD, 16'h0001);
    queue_op(MODE_ADD, 16'h0002);
    queue_op(MODE_ADD, 16'h0003);
    queue_op(MODE_ADD, 16'h0004);
    queue_op(MODE_ADD, 16'h0002);
    queue_op(MODE_REMOVE, 16'h0003);
    queue_op(MODE_REMOVE, 16'h0003);
    queue_op(MODE_ADD, 16'hFFFF);
    queue_op(MODE_ADD, 16'hAAAA);
    queue_op(MODE_ADD, 16'h5555);
    wait_idle();

    // lowering the limit only bites at the next add
    write_capacity(5'd1);
    queue_op(MODE_ADD, 16'h5555);
    wait_idle();

    phase_caps = '{5'd16, 5'd31, 5'd1, 5'd4, 5'd0, 5'd9, 5'($urandom_range(0, 16))};
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph % 3 == 1);
      write_capacity(phase_caps[ph]);
      pool_base = 16'($urandom) & 16'hFFC0;
      pool_size = ((phase_caps[ph] > ENTRIES) ? ENTRIES : phase_caps[ph]) + 6;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0)
          queue_op(1'($urandom), 16'($urandom));
        else
          queue_op(($urandom_range(0, 99) < 35) ? MODE_REMOVE : MODE_ADD,
                   pool_base + 16'($urandom_range(0, pool_size - 1)));
      end
      wait_idle();
    end
    no_idle = 1'b0;

    // full table, then capacity zero: one add flushes every entry and itself
    write_capacity(5'd16);
    for (n = 0; n < ENTRIES; n++) queue_op(MODE_ADD, 16'h8000 + 16'(n));
    wait_idle();
    write_capacity(5'd0);
    queue_op(MODE_ADD, 16'h1234);
    wait_idle();
    repeat (20) @(posedge clk);

    if (release_q.size() != 0) begin
      $error("%0d expected results never arrived", release_q.size());
      fail_count++;
    end
    $display("covered %0d cache ops, %0d release transfers, longest run %0d",
             ops_accepted, results_seen, longest_run);
    $display("by reason: none %0d, stale %0d, removed %0d, evicted %0d",
             reason_seen[RSN_NONE], reason_seen[RSN_STALE],
             reason_seen[RSN_REMOVE], reason_seen[RSN_EVICT]);
    if (fail_count == 0) begin
      $display("lru_capacity_eviction_table regression: pass");
    end else begin
      $display("lru_capacity_eviction_table regression: fail");
    end
    $finish;
  end

endmodule
